// ----- rtl/spq_pkg.sv -----
// Shared types, codes and defaults of the sorted priority queue.
`default_nettype none
package spq_pkg;

  localparam int unsigned DefaultDepth = 8;
  localparam int unsigned ValueWidth   = 32;
  localparam int unsigned OccWidth     = 4;

  localparam logic OpInsert = 1'b0;
  localparam logic OpRemove = 1'b1;

  typedef enum logic [1:0] {
    StatusDone  = 2'd0,
    StatusFull  = 2'd1,
    StatusEmpty = 2'd2
  } status_e;

  typedef struct packed {
    logic                         opcode;
    logic signed [ValueWidth-1:0] value_in;
  } req_t;

  typedef struct packed {
    logic signed [ValueWidth-1:0] removed_value;
    logic [1:0]                   status;
    logic [OccWidth-1:0]          occupancy;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic exec;
  } cmd_t;

endpackage
`default_nettype wire

// ----- rtl/sorted_priority_queue_unit.sv -----
// Top level of the sorted priority queue: controller plus datapath.
//
// Usage: drive req_i (opcode, value_in) and raise start. A transaction is
// taken at a rising edge where start is high and busy is low. Insert
// (opcode 0) places value_in in ascending order; remove (opcode 1) returns
// the smallest value held. Each transaction yields one response on rsp_o
// (removed_value, status, occupancy), valid for exactly one cycle while
// done_o is high; the receiver cannot stall it and must take it then.
// done_o is registered and rises once the execute state that follows the
// accepting edge has ended. The queue takes no new transaction while busy,
// during the execute state in which every entry of the shift array moves
// in parallel, comparing against the new value on an insert; a new
// transaction may be taken in the response cycle.
// Status 1 means the insert was dropped because DEPTH values are held,
// status 2 that a remove found the queue empty; removed_value is zero in
// both cases and on inserts. Occupancy is the count after the transaction.
// Reset (rst_ni low, asynchronous) empties the queue and returns the
// controller to idle; stored values are not cleared and need no sweep.
`default_nettype none
module sorted_priority_queue_unit #(
  parameter int unsigned DEPTH = spq_pkg::DefaultDepth
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  input  wire spq_pkg::req_t req_i,
  output logic               done_o,
  output spq_pkg::rsp_t      rsp_o
);

  spq_pkg::cmd_t cmd;

  spq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .cmd_o  (cmd)
  );

  spq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .req_i  (req_i),
    .rsp_o  (rsp_o)
  );

endmodule
`default_nettype wire

// ----- rtl/spq_ctrl.sv -----
// Sequencing state machine of the sorted priority queue.
`default_nettype none
module spq_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  output logic               done_o,
  output spq_pkg::cmd_t      cmd_o
);

  typedef enum logic [1:0] {
    StIdle,
    StExec,
    StResp
  } state_e;

  state_e state_q;
  logic   busy_q;
  logic   done_q;
  logic   accept;

  assign accept     = start && !busy_q;
  assign busy       = busy_q;
  assign done_o     = done_q;
  assign cmd_o.load = accept;
  assign cmd_o.exec = (state_q == StExec);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      unique case (state_q)
        StIdle, StResp: begin
          done_q <= 1'b0;
          if (accept) begin
            state_q <= StExec;
            busy_q  <= 1'b1;
          end else begin
            state_q <= StIdle;
          end
        end
        StExec: begin
          state_q <= StResp;
          busy_q  <= 1'b0;
          done_q  <= 1'b1;
        end
        default: begin
          state_q <= StIdle;
          busy_q  <= 1'b0;
          done_q  <= 1'b0;
        end
      endcase
    end
  end

  a_busy_means_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q == (state_q == StExec))
    else $error("busy out of step with state");

  a_done_after_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StExec) |=> done_q)
    else $error("no strobe after execution");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("strobe longer than one cycle");

endmodule
`default_nettype wire

// ----- rtl/spq_datapath.sv -----
// Sorted entry array, counter and result register of the priority queue.
`default_nettype none
module spq_datapath #(
  parameter int unsigned DEPTH = spq_pkg::DefaultDepth
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire spq_pkg::cmd_t cmd_i,
  input  wire spq_pkg::req_t req_i,
  output spq_pkg::rsp_t      rsp_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic signed [spq_pkg::ValueWidth-1:0] entry_q [DEPTH];
  logic signed [spq_pkg::ValueWidth-1:0] entry_d [DEPTH];
  logic [CW-1:0]                         count_q, count_d;
  logic                                  op_q;
  logic signed [spq_pkg::ValueWidth-1:0] val_q;
  spq_pkg::rsp_t                         rsp_q, rsp_d;
  logic [DEPTH-1:0]                      gt;
  logic                                  full, empty;

  assign full  = (count_q == CW'(DEPTH));
  assign empty = (count_q == '0);

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      gt[i] = (count_q > CW'(i)) && (entry_q[i] > val_q);
    end
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      entry_d[i] = entry_q[i];
    end
    count_d             = count_q;
    rsp_d.removed_value = '0;
    rsp_d.status        = spq_pkg::StatusDone;
    if (op_q == spq_pkg::OpInsert) begin
      if (full) begin
        rsp_d.status = spq_pkg::StatusFull;
      end else begin
        if (gt[0] || empty) begin
          entry_d[0] = val_q;
        end
        for (int i = 1; i < DEPTH; i++) begin
          if (gt[i-1]) begin
            entry_d[i] = entry_q[i-1];
          end else if (gt[i] || (count_q == CW'(i))) begin
            entry_d[i] = val_q;
          end
        end
        count_d = count_q + 1'b1;
      end
    end else begin
      if (empty) begin
        rsp_d.status = spq_pkg::StatusEmpty;
      end else begin
        rsp_d.removed_value = entry_q[0];
        for (int i = 0; i < DEPTH - 1; i++) begin
          entry_d[i] = entry_q[i+1];
        end
        count_d = count_q - 1'b1;
      end
    end
    rsp_d.occupancy = spq_pkg::OccWidth'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.exec) begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= req_i.opcode;
      val_q <= req_i.value_in;
    end
    if (cmd_i.exec) begin
      rsp_q <= rsp_d;
      for (int i = 0; i < DEPTH; i++) begin
        entry_q[i] <= entry_d[i];
      end
    end
  end

  assign rsp_o = rsp_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("count beyond depth");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && op_q == spq_pkg::OpInsert && !full)
      |=> count_q == $past(count_q) + 1'b1)
    else $error("insert did not grow the queue");

  a_empty_reported: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && op_q == spq_pkg::OpRemove && empty)
      |=> (rsp_q.status == spq_pkg::StatusEmpty) && (rsp_q.removed_value == '0))
    else $error("empty remove misreported");

endmodule
`default_nettype wire
